// ===== rtl/qcrq_pkg.sv =====
`timescale 1ns / 1ps

package qcrq_pkg;

    localparam int CNT_W  = 11;
    localparam int REQ_W  = 3;
    localparam int CHAR_W = 8;
    localparam int ST_W   = 2;
    localparam int ENT_W  = CHAR_W + 1;

    localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

    localparam logic [REQ_W-1:0] REQ_PUT   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_GET   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_UNPUT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FLUSH = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PEEK  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_GET,
        OP_UNPUT,
        OP_FLUSH,
        OP_PEEK,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] char_in;
        logic              quote_in;
        logic [CNT_W-1:0]  amount;
    } cmd_t;

    typedef enum logic {
        BK_EXEC,
        BK_LOAD
    } back_state_t;

endpackage

// ===== rtl/qcrq_front.sv =====
`timescale 1ns / 1ps

module qcrq_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [qcrq_pkg::REQ_W-1:0] s_req_type,
    input  logic [qcrq_pkg::CHAR_W-1:0] s_char_in,
    input  logic                       s_quote_in,
    input  logic [qcrq_pkg::CNT_W-1:0] s_amount,
    output logic                       f_valid,
    input  logic                       f_ready,
    output qcrq_pkg::cmd_t             f_cmd
);
    import qcrq_pkg::*;

    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic vld_reg;
    logic vld_next;
    logic take;

    assign s_ready = !vld_reg || f_ready;
    assign take    = s_valid && s_ready;
    assign f_valid = vld_reg;
    assign f_cmd   = cmd_reg;

    always_comb begin
        cmd_next.char_in  = s_char_in;
        cmd_next.quote_in = s_quote_in;
        cmd_next.amount   = s_amount;
        case (s_req_type)
            REQ_PUT:   cmd_next.op = OP_PUT;
            REQ_GET:   cmd_next.op = OP_GET;
            REQ_UNPUT: cmd_next.op = OP_UNPUT;
            REQ_FLUSH: cmd_next.op = OP_FLUSH;
            REQ_PEEK:  cmd_next.op = OP_PEEK;
            default:   cmd_next.op = OP_NOP;
        endcase
    end

    always_comb begin
        if (take) begin
            vld_next = 1'b1;
        end else if (f_ready) begin
            vld_next = 1'b0;
        end else begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// ===== rtl/qcrq_fifo.sv =====
`timescale 1ns / 1ps

module qcrq_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  qcrq_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output qcrq_pkg::cmd_t out_cmd
);
    import qcrq_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    logic       pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== rtl/qcrq_back.sv =====
`timescale 1ns / 1ps

module qcrq_back #(
    parameter int DEPTH = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wen,
    input  logic [qcrq_pkg::CNT_W-1:0]  cfg_wdata,
    input  logic                        c_valid,
    output logic                        c_ready,
    input  qcrq_pkg::cmd_t              c_cmd,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [qcrq_pkg::ST_W-1:0]   m_status,
    output logic [qcrq_pkg::CHAR_W-1:0] m_char_out,
    output logic                        m_quote_out,
    output logic [qcrq_pkg::CNT_W-1:0]  m_fill_count,
    output logic [qcrq_pkg::CNT_W-1:0]  m_flushed_count
);
    import qcrq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int PW = (AW > CNT_W) ? AW : CNT_W;
    localparam logic [CNT_W-1:0] CAP_RST_EFF =
        (DEPTH < 1024) ? CNT_W'(DEPTH) : CAP_RESET;

    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] mem_q;

    back_state_t      state_reg;
    back_state_t      state_next;
    logic [CNT_W-1:0] cap_reg;
    logic [AW-1:0]    head_reg;
    logic [AW-1:0]    head_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rd_pend_reg;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [ST_W-1:0]  status_reg;
    logic [ST_W-1:0]  status_next;
    logic [CHAR_W-1:0] char_reg;
    logic             quote_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] flushed_reg;

    logic             issue;
    logic             rd_en;
    logic             wr_en;
    logic [CNT_W-1:0] off;
    logic [CNT_W-1:0] flushed;
    logic [PW:0]      sum;
    logic [PW:0]      wrapped;
    logic [AW-1:0]    slot;
    logic [PW:0]      inc;
    logic [AW-1:0]    head_inc;
    logic [CNT_W-1:0] cap_wr;

    // shared wrap adder: logical offset from head to physical slot
    assign flushed = (c_cmd.amount > count_reg) ? count_reg : c_cmd.amount;
    assign sum     = (PW+1)'(head_reg) + (PW+1)'(off);
    assign wrapped = (sum >= (PW+1)'(cap_reg)) ? sum - (PW+1)'(cap_reg) : sum;
    assign slot    = AW'(wrapped);
    assign inc     = (PW+1)'(head_reg) + (PW+1)'(1);
    assign head_inc = (inc >= (PW+1)'(cap_reg)) ? '0 : AW'(inc);
    assign cap_wr  = ((PW+1)'(cfg_wdata) > (PW+1)'(DEPTH)) ? CNT_W'(DEPTH) : cfg_wdata;

    always_comb begin
        case (c_cmd.op)
            OP_PUT:   off = count_reg;
            OP_UNPUT: off = count_reg - CNT_W'(1);
            OP_FLUSH: off = flushed;
            OP_PEEK:  off = c_cmd.amount;
            default:  off = '0;
        endcase
    end

    always_comb begin
        status_next = ST_OK;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        head_next   = head_reg;
        count_next  = count_reg;
        case (c_cmd.op)
            OP_PUT: begin
                if (count_reg >= cap_reg) begin
                    status_next = ST_FULL;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_GET: begin
                if (count_reg == '0) begin
                    status_next = ST_EMPTY;
                end else begin
                    rd_en      = 1'b1;
                    head_next  = head_inc;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_UNPUT: begin
                if (count_reg == '0) begin
                    status_next = ST_EMPTY;
                end else begin
                    rd_en      = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_FLUSH: begin
                if (flushed != '0) begin
                    head_next = slot;
                end
                count_next = count_reg - flushed;
            end
            OP_PEEK: begin
                if (count_reg == '0) begin
                    status_next = ST_EMPTY;
                end else if (c_cmd.amount >= count_reg) begin
                    status_next = ST_RANGE;
                end else begin
                    rd_en = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        case (state_reg)
            BK_EXEC: state_next = issue ? BK_LOAD : BK_EXEC;
            BK_LOAD: state_next = BK_EXEC;
            default: state_next = BK_EXEC;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        issue        = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            BK_EXEC: issue = c_valid && (!m_valid_reg || m_ready);
            BK_LOAD: m_valid_next = 1'b1;
            default: begin
            end
        endcase
    end

    assign c_ready         = issue;
    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_char_out      = char_reg;
    assign m_quote_out     = quote_reg;
    assign m_fill_count    = fill_reg;
    assign m_flushed_count = flushed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_EXEC;
            cap_reg     <= CAP_RST_EFF;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (issue) begin
                rd_pend_reg <= rd_en;
            end
            if (cfg_wen) begin
                cap_reg   <= cap_wr;
                head_reg  <= '0;
                count_reg <= '0;
            end else if (issue) begin
                head_reg  <= head_next;
                count_reg <= count_next;
            end
        end
    end

    // the previous beat leaves at the issue edge, so these may be overwritten then
    always_ff @(posedge aclk) begin
        if (issue) begin
            status_reg  <= status_next;
            fill_reg    <= count_next;
            flushed_reg <= (c_cmd.op == OP_FLUSH) ? flushed : '0;
        end
        if (state_reg == BK_LOAD) begin
            char_reg  <= rd_pend_reg ? mem_q[CHAR_W-1:0] : '0;
            quote_reg <= rd_pend_reg ? mem_q[CHAR_W] : 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue && wr_en) begin
            mem[slot] <= {c_cmd.quote_in, c_cmd.char_in};
        end
        if (issue && rd_en) begin
            mem_q <= mem[slot];
        end
    end

    a_count_le_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cap_reg)
        else $error("fill count above capacity");

    a_head_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((PW+1)'(head_reg) < (PW+1)'(cap_reg)) || (head_reg == '0))
        else $error("head index outside capacity");

    a_load_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_LOAD) |-> !m_valid_reg)
        else $error("result register busy while loading");

    a_valid_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == BK_LOAD))
        else $error("result beat without an executed operation");

endmodule

// ===== rtl/quoted_char_ring_queue_unit.sv =====
`timescale 1ns / 1ps

// Circular character queue for a terminal line; entries are a character
// plus a quote flag. Requests (put, get, unput, flush, peek) arrive on the
// s_ channel, one result beat per request leaves on the m_ channel.
// Capacity is written through cfg_wen/cfg_wdata while the block is idle;
// every write empties the queue, values above DEPTH saturate at DEPTH.
// A front stage decodes each request into a two-entry command queue; the
// back end executes one command against head, fill count and the entry RAM.
// A request passes the front register and the command queue to the execute
// state; m_valid rises as the load state, the registered read of the
// single-port entry RAM, ends. No new command is taken during that load.
// Stall on m_ready holds the result register; the command queue and the
// front register then take three more beats before s_ready drops.
// Reset: queue empty, head 0, capacity min(1024, DEPTH). The entry RAM is
// not cleared; no entry is read before it is written.
module quoted_char_ring_queue_unit #(
    parameter int DEPTH = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wen,
    input  logic [qcrq_pkg::CNT_W-1:0]  cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [qcrq_pkg::REQ_W-1:0]  s_req_type,
    input  logic [qcrq_pkg::CHAR_W-1:0] s_char_in,
    input  logic                        s_quote_in,
    input  logic [qcrq_pkg::CNT_W-1:0]  s_amount,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [qcrq_pkg::ST_W-1:0]   m_status,
    output logic [qcrq_pkg::CHAR_W-1:0] m_char_out,
    output logic                        m_quote_out,
    output logic [qcrq_pkg::CNT_W-1:0]  m_fill_count,
    output logic [qcrq_pkg::CNT_W-1:0]  m_flushed_count
);
    import qcrq_pkg::*;

    logic f_valid;
    logic f_ready;
    cmd_t f_cmd;
    logic c_valid;
    logic c_ready;
    cmd_t c_cmd;

    qcrq_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_char_in  (s_char_in),
        .s_quote_in (s_quote_in),
        .s_amount   (s_amount),
        .f_valid    (f_valid),
        .f_ready    (f_ready),
        .f_cmd      (f_cmd)
    );

    qcrq_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_cmd   (c_cmd)
    );

    qcrq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wen         (cfg_wen),
        .cfg_wdata       (cfg_wdata),
        .c_valid         (c_valid),
        .c_ready         (c_ready),
        .c_cmd           (c_cmd),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_char_out      (m_char_out),
        .m_quote_out     (m_quote_out),
        .m_fill_count    (m_fill_count),
        .m_flushed_count (m_flushed_count)
    );

endmodule

// ===== dv/quoted_char_ring_queue_unit_tb.sv =====
`timescale 1ns / 1ps

module quoted_char_ring_queue_unit_tb;
    import qcrq_pkg::*;

    localparam int QDEPTH        = 1024;
    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 80;
    localparam int LIMIT_NS      = 5_000_000;

    // request codes the block must ignore
    localparam logic [REQ_W-1:0] REQ_SPARE_LO  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE_MID = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI  = 3'd7;

    typedef struct packed {
        logic              wait_drain;
        logic [REQ_W-1:0]  req;
        logic [CHAR_W-1:0] ch;
        logic              quote;
        logic [CNT_W-1:0]  amount;
    } line_req_t;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [CHAR_W-1:0] ch;
        logic              quote;
        logic [CNT_W-1:0]  fill;
        logic [CNT_W-1:0]  flushed;
    } line_reply_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wen = 1'b0;
    logic [CNT_W-1:0]  cfg_wdata = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [REQ_W-1:0]  s_req_type = '0;
    logic [CHAR_W-1:0] s_char_in = '0;
    logic              s_quote_in = 1'b0;
    logic [CNT_W-1:0]  s_amount = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [ST_W-1:0]   m_status;
    logic [CHAR_W-1:0] m_char_out;
    logic              m_quote_out;
    logic [CNT_W-1:0]  m_fill_count;
    logic [CNT_W-1:0]  m_flushed_count;

    line_req_t   pending_line_reqs[$];
    line_reply_t queue_replies_due[$];
    line_req_t   req_on_bus;
    line_reply_t reply_seen;
    line_reply_t reply_due;

    // shadow of the character queue
    logic [ENT_W-1:0] shadow_chars [0:QDEPTH-1];
    int               shadow_head = 0;
    int               shadow_fill = 0;
    int               shadow_cap  = int'(CAP_RESET);

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int src_gap       = 0;
    int sink_hold     = 0;
    int long_holds_asked = 0;
    int long_holds_done  = 0;
    int mismatches       = 0;

    quoted_char_ring_queue_unit #(
        .DEPTH(QDEPTH)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wen        (cfg_wen),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_char_in      (s_char_in),
        .s_quote_in     (s_quote_in),
        .s_amount       (s_amount),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_char_out     (m_char_out),
        .m_quote_out    (m_quote_out),
        .m_fill_count   (m_fill_count),
        .m_flushed_count(m_flushed_count)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic line_reply_t run_line_op(line_req_t r);
        line_reply_t rep;
        int          cap;
        int          slot;
        int          amt;
        int          take;
        rep = '0;
        rep.status = ST_OK;
        cap = (shadow_cap > QDEPTH) ? QDEPTH : shadow_cap;
        amt = int'(r.amount);
        case (r.req)
            REQ_PUT: begin
                if (shadow_fill >= cap) begin
                    rep.status = ST_FULL;
                end else begin
                    slot = shadow_head + shadow_fill;
                    if (slot >= cap) slot -= cap;
                    shadow_chars[slot] = {r.quote, r.ch};
                    shadow_fill++;
                end
            end
            REQ_GET: begin
                if (shadow_fill == 0) begin
                    rep.status = ST_EMPTY;
                end else begin
                    {rep.quote, rep.ch} = shadow_chars[shadow_head];
                    shadow_head++;
                    if (shadow_head >= cap) shadow_head = 0;
                    shadow_fill--;
                end
            end
            REQ_UNPUT: begin
                if (shadow_fill == 0) begin
                    rep.status = ST_EMPTY;
                end else begin
                    shadow_fill--;
                    slot = shadow_head + shadow_fill;
                    if (slot >= cap) slot -= cap;
                    {rep.quote, rep.ch} = shadow_chars[slot];
                end
            end
            REQ_FLUSH: begin
                take = (amt > shadow_fill) ? shadow_fill : amt;
                if (take > 0) begin
                    shadow_head += take;
                    if (shadow_head >= cap) shadow_head -= cap;
                end
                shadow_fill -= take;
                rep.flushed = CNT_W'(take);
            end
            REQ_PEEK: begin
                if (shadow_fill == 0) begin
                    rep.status = ST_EMPTY;
                end else if (amt >= shadow_fill) begin
                    rep.status = ST_RANGE;
                end else begin
                    slot = shadow_head + amt;
                    if (slot >= cap) slot -= cap;
                    {rep.quote, rep.ch} = shadow_chars[slot];
                end
            end
            default: begin
            end
        endcase
        rep.fill = CNT_W'(shadow_fill);
        return rep;
    endfunction

    function automatic string fmt_reply(line_reply_t r);
        return $sformatf("st=%0d ch=%02h q=%0b fill=%0d flushed=%0d",
                         r.status, r.ch, r.quote, r.fill, r.flushed);
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                queue_replies_due.push_back(run_line_op(req_on_bus));
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_line_reqs.size() > 0 && pending_line_reqs[0].wait_drain) begin
                    // hold off until every reply is back
                    s_valid <= 1'b0;
                    if (queue_replies_due.size() == 0) void'(pending_line_reqs.pop_front());
                end else if (pending_line_reqs.size() > 0) begin
                    req_on_bus = pending_line_reqs.pop_front();
                    s_valid    <= 1'b1;
                    s_req_type <= req_on_bus.req;
                    s_char_in  <= req_on_bus.ch;
                    s_quote_in <= req_on_bus.quote;
                    s_amount   <= req_on_bus.amount;
                    if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct)
                        src_gap = $urandom_range(1, 11);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // reply monitor and m_ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                reply_seen = '{m_status, m_char_out, m_quote_out, m_fill_count, m_flushed_count};
                if (queue_replies_due.size() == 0) begin
                    $display("%0t unexpected reply beat: exp none got %s", $time,
                             fmt_reply(reply_seen));
                    mismatches++;
                end else begin
                    reply_due = queue_replies_due.pop_front();
                    if (reply_seen.status !== reply_due.status || reply_seen.ch !== reply_due.ch ||
                        reply_seen.quote !== reply_due.quote || reply_seen.fill !== reply_due.fill ||
                        reply_seen.flushed !== reply_due.flushed) begin
                        $display("%0t reply mismatch: exp %s got %s", $time,
                                 fmt_reply(reply_due), fmt_reply(reply_seen));
                        mismatches++;
                    end
                end
            end
            if (long_holds_done < long_holds_asked) begin
                long_holds_done++;
                sink_hold = LONG_HOLD;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_ready <= 1'b0;
            end else if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct) begin
                sink_hold = $urandom_range(0, 10);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic queue_req(logic [REQ_W-1:0] req, logic [CHAR_W-1:0] ch, logic quote,
                             logic [CNT_W-1:0] amount);
        pending_line_reqs.push_back('{1'b0, req, ch, quote, amount});
    endtask

    task automatic queue_drain();
        pending_line_reqs.push_back('{1'b1, REQ_PUT, 8'h00, 1'b0, 11'd0});
    endtask

    task automatic wait_for_drain();
        while (pending_line_reqs.size() != 0 || s_valid || queue_replies_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // capacity write empties the queue, so only between phases
    task automatic write_capacity(logic [CNT_W-1:0] value);
        wait_for_drain();
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        shadow_cap  = int'(value);
        shadow_head = 0;
        shadow_fill = 0;
    endtask

    task automatic queue_random_reqs(int n, int cap);
        int        pick;
        int        span;
        line_req_t r;
        span = (cap > QDEPTH) ? QDEPTH : cap;
        for (int i = 0; i < n; i++) begin
            r.wait_drain = 1'b0;
            r.ch     = CHAR_W'($urandom_range(0, 255));
            r.quote  = 1'($urandom_range(0, 1));
            r.amount = CNT_W'($urandom_range(0, 2047));
            pick = $urandom_range(0, 99);
            if (pick < 40)      r.req = REQ_PUT;
            else if (pick < 58) r.req = REQ_GET;
            else if (pick < 66) r.req = REQ_UNPUT;
            else if (pick < 76) r.req = REQ_FLUSH;
            else if (pick < 94) r.req = REQ_PEEK;
            else                r.req = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
            // most offsets and flush counts drawn from 0 to the capacity plus one
            if ((r.req == REQ_FLUSH || r.req == REQ_PEEK) && $urandom_range(0, 3) != 0)
                r.amount = CNT_W'($urandom_range(0, span + 1));
            pending_line_reqs.push_back(r);
        end
    endtask

    initial begin
        logic [CNT_W-1:0] mid_cap;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty cases, byte extremes, range errors, spare codes, clamping
        src_idle_pct  = 20;
        sink_idle_pct = 20;
        queue_req(REQ_GET,   8'h00, 1'b0, 11'd0);
        queue_req(REQ_UNPUT, 8'h00, 1'b0, 11'd0);
        queue_req(REQ_PEEK,  8'h00, 1'b0, 11'd0);
        queue_req(REQ_FLUSH, 8'h00, 1'b0, 11'd2047);
        queue_req(REQ_PUT,   8'h00, 1'b0, 11'd0);
        queue_req(REQ_PUT,   8'hFF, 1'b1, 11'd2047);
        queue_req(REQ_PUT,   8'hA5, 1'b0, 11'd0);
        queue_req(REQ_PUT,   8'h5A, 1'b1, 11'd1024);
        queue_req(REQ_PEEK,  8'h00, 1'b0, 11'd0);
        queue_req(REQ_PEEK,  8'h00, 1'b0, 11'd3);
        queue_req(REQ_PEEK,  8'h00, 1'b0, 11'd4);
        queue_req(REQ_PEEK,  8'hFF, 1'b1, 11'd2047);
        queue_req(REQ_SPARE_LO,  8'hFF, 1'b1, 11'd2047);
        queue_req(REQ_SPARE_MID, 8'h3C, 1'b0, 11'd1);
        queue_req(REQ_SPARE_HI,  8'h00, 1'b1, 11'd0);
        queue_drain();
        queue_req(REQ_GET,   8'h00, 1'b0, 11'd0);
        queue_req(REQ_UNPUT, 8'h00, 1'b0, 11'd0);
        queue_req(REQ_FLUSH, 8'h00, 1'b0, 11'd1);
        queue_req(REQ_FLUSH, 8'h00, 1'b0, 11'd2047);
        queue_req(REQ_FLUSH, 8'h00, 1'b0, 11'd0);
        queue_req(REQ_PUT,   8'h7E, 1'b1, 11'd0);
        queue_req(REQ_GET,   8'h00, 1'b0, 11'd0);

        write_capacity(11'd0);
        queue_random_reqs(10, 0);

        write_capacity(11'd1);
        queue_random_reqs(15, 1);

        // above DEPTH: must saturate; long sink stall while the source keeps going
        write_capacity(11'd2047);
        src_idle_pct  = 0;
        sink_idle_pct = 15;
        long_holds_asked++;
        for (int i = 0; i < QDEPTH + 2; i++) begin
            queue_req(REQ_PUT, CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      CNT_W'($urandom_range(0, 2047)));
            if (i % 64 == 63)
                queue_req(REQ_PEEK, 8'h00, 1'b0, CNT_W'($urandom_range(0, i)));
        end
        // move the head near the top so tail and head both wrap
        queue_req(REQ_FLUSH, 8'h00, 1'b0, CNT_W'(QDEPTH - 24));
        for (int i = 0; i < 26; i++)
            queue_req(REQ_PUT, CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      11'd0);
        for (int i = 0; i < 30; i++) begin
            queue_req(REQ_GET, 8'h00, 1'b0, 11'd0);
            if (i % 10 == 9)
                queue_req(REQ_PEEK, 8'h00, 1'b0, CNT_W'($urandom_range(0, 20)));
        end
        queue_req(REQ_UNPUT, 8'h00, 1'b0, 11'd0);
        queue_req(REQ_FLUSH, 8'h00, 1'b0, 11'd2047);

        write_capacity(11'd3);
        src_idle_pct  = 25;
        sink_idle_pct = 25;
        queue_random_reqs(15, 3);

        write_capacity(11'd7);
        src_idle_pct  = 15;
        sink_idle_pct = 30;
        queue_random_reqs(8, 7);
        queue_drain();
        queue_random_reqs(8, 7);

        mid_cap = CNT_W'($urandom_range(2, 16));
        write_capacity(mid_cap);
        src_idle_pct  = 30;
        sink_idle_pct = 10;
        queue_random_reqs(15, int'(mid_cap));

        // closing stretch at full rate
        write_capacity(11'd1024);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        queue_random_reqs(15, 4);

        wait_for_drain();
        if (mismatches == 0) begin
            $display("[quoted_char_ring_queue_unit] OK");
        end else begin
            $display("[quoted_char_ring_queue_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("[quoted_char_ring_queue_unit] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/qcrq_pkg.sv
rtl/qcrq_front.sv
rtl/qcrq_fifo.sv
rtl/qcrq_back.sv
rtl/quoted_char_ring_queue_unit.sv
dv/quoted_char_ring_queue_unit_tb.sv
